/* hw/rtl/u8sdc_pkg.sv */
// Package: types, constants and decode functions for the UTF-8 script direction counter.
package u8sdc_pkg;

  localparam int COUNT_BITS = 24;
  localparam int OUT_BITS   = 24;
  localparam int CP_BITS    = 21;

  localparam logic [CP_BITS-1:0] RTL_A_LO = 21'h000590;
  localparam logic [CP_BITS-1:0] RTL_A_HI = 21'h00074F;
  localparam logic [CP_BITS-1:0] RTL_B_LO = 21'h000780;
  localparam logic [CP_BITS-1:0] RTL_B_HI = 21'h0007BF;
  localparam logic [CP_BITS-1:0] UPPER_LO = 21'h000041;
  localparam logic [CP_BITS-1:0] UPPER_HI = 21'h00005A;
  localparam logic [CP_BITS-1:0] LOWER_LO = 21'h000061;
  localparam logic [CP_BITS-1:0] LOWER_HI = 21'h00007A;
  localparam logic [CP_BITS-1:0] GREEK_LO = 21'h000370;
  localparam logic [CP_BITS-1:0] CYRIL_HI = 21'h0004FF;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_RTL,
    DIR_LTR
  } dir_t;

  typedef struct packed {
    logic [1:0] rtl_inc;
    logic [1:0] ltr_inc;
  } dir_cnt_t;

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] n;
    priority if (c[7] == 1'b0) n = 3'd1;
    else if (c[7:5] == 3'b110) n = 3'd2;
    else if (c[7:4] == 4'b1110) n = 3'd3;
    else if (c[7:3] == 5'b11110) n = 3'd4;
    else n = 3'd0;
    return n;
  endfunction

  function automatic logic [CP_BITS-1:0] decode_cp(input logic [7:0] b0, input logic [7:0] b1,
                                                   input logic [7:0] b2, input logic [7:0] b3,
                                                   input logic [2:0] n);
    logic [CP_BITS-1:0] cp;
    unique case (n)
      3'd2:    cp = CP_BITS'({b0[4:0], b1[5:0]});
      3'd3:    cp = CP_BITS'({b0[3:0], b1[5:0], b2[5:0]});
      3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = CP_BITS'(b0);
    endcase
    return cp;
  endfunction

  function automatic dir_t classify_cp(input logic [CP_BITS-1:0] cp);
    dir_t d;
    priority if ((cp >= RTL_A_LO && cp <= RTL_A_HI) || (cp >= RTL_B_LO && cp <= RTL_B_HI))
      d = DIR_RTL;
    else if ((cp >= UPPER_LO && cp <= UPPER_HI) || (cp >= LOWER_LO && cp <= LOWER_HI) ||
             (cp >= GREEK_LO && cp <= CYRIL_HI))
      d = DIR_LTR;
    else
      d = DIR_NONE;
    return d;
  endfunction

  function automatic dir_cnt_t count_one(input dir_t d);
    dir_cnt_t c;
    c = '0;
    if (d == DIR_RTL) c.rtl_inc = 2'd1;
    if (d == DIR_LTR) c.ltr_inc = 2'd1;
    return c;
  endfunction

  // Decode the bytes after a dropped lead, up to the end of the string.
  function automatic dir_cnt_t tail_count(input logic [7:0] t0, input logic [7:0] t1,
                                          input logic [7:0] t2, input logic [1:0] len);
    logic [7:0] t [4];
    logic [2:0] pos;
    logic [2:0] n;
    logic [2:0] lim;
    dir_t       d;
    dir_cnt_t   c;
    t[0] = t0;
    t[1] = t1;
    t[2] = t2;
    t[3] = 8'h00;
    lim  = {1'b0, len};
    pos  = 3'd0;
    c    = '0;
    for (int s = 0; s < 3; s++) begin
      if (pos < lim) begin
        n = lead_len(t[pos[1:0]]);
        if (n == 3'd0 || (pos + n) > lim) begin
          pos = pos + 3'd1;
        end else begin
          d = classify_cp(decode_cp(t[pos[1:0]], t[2'(pos + 3'd1)], t[2'(pos + 3'd2)],
                                    t[2'(pos + 3'd3)], n));
          if (d == DIR_RTL) c.rtl_inc = c.rtl_inc + 2'd1;
          if (d == DIR_LTR) c.ltr_inc = c.ltr_inc + 2'd1;
          pos = pos + n;
        end
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/utf8_script_direction_counter_unit.sv */
// UTF-8 script direction counter: top level with input stage, decode and count registers.
// An accepted request passes the input stage register and then the result register to the master side.
// Throughput: one byte per cycle while m_tready lets results drain; pending and count registers update each advance.
// Backpressure holds the input stage and the result register; neither drops data.
// Reset (rst, synchronous, active high) empties both stages and zeroes counts and pending length.
module utf8_script_direction_counter_unit
  import u8sdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // last_of_string
  input  logic        s_tuser,   // clear_counts
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [23:0] rtl_count, [47:24] ltr_count
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  in_last;
  logic                  in_clear;
  logic                  advance;

  logic [7:0]            p0;
  logic [7:0]            p1;
  logic [7:0]            p2;
  logic [1:0]            plen;
  logic [1:0]            plen_next;
  logic [COUNT_BITS-1:0] rtl_total;
  logic [COUNT_BITS-1:0] ltr_total;
  logic [COUNT_BITS-1:0] rtl_total_next;
  logic [COUNT_BITS-1:0] ltr_total_next;

  logic [7:0]            buf1;
  logic [7:0]            buf2;
  logic [2:0]            need;
  logic [2:0]            total;
  logic [2:0]            n_new;
  dir_cnt_t              inc;

  logic                  out_valid;
  logic [47:0]           out_data;
  logic [31:0]           rtl_wide;
  logic [31:0]           ltr_wide;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] base,
                                                    input logic [1:0] step);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, base} + (COUNT_BITS+1)'(step);
    return sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
  endfunction

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Assemble the held sequence with the new byte.
  assign buf1  = (plen == 2'd1) ? in_byte : p1;
  assign buf2  = (plen == 2'd2) ? in_byte : p2;
  assign need  = lead_len(p0);
  assign total = {1'b0, plen} + 3'd1;
  assign n_new = lead_len(in_byte);

  always_comb begin
    inc       = '0;
    plen_next = plen;
    if (plen == 2'd0) begin
      if (n_new == 3'd1) begin
        inc = count_one(classify_cp(CP_BITS'(in_byte)));
      end else if (n_new >= 3'd2 && !in_last) begin
        plen_next = 2'd1;
      end
    end else if (need <= total) begin
      inc       = count_one(classify_cp(decode_cp(p0, buf1, buf2, in_byte, need)));
      plen_next = 2'd0;
    end else if (in_last) begin
      inc       = tail_count(buf1, buf2, in_byte, plen);
      plen_next = 2'd0;
    end else if (total <= 3'd3) begin
      plen_next = plen + 2'd1;
    end else begin
      plen_next = 2'd0;
    end
  end

  always_comb begin
    rtl_total_next = sat_add(in_clear ? '0 : rtl_total, inc.rtl_inc);
    ltr_total_next = sat_add(in_clear ? '0 : ltr_total, inc.ltr_inc);
    rtl_wide       = 32'(rtl_total_next);
    ltr_wide       = 32'(ltr_total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_last  <= s_tlast;
      in_clear <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen      <= 2'd0;
      rtl_total <= '0;
      ltr_total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        plen      <= plen_next;
        rtl_total <= rtl_total_next;
        ltr_total <= ltr_total_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {ltr_wide[OUT_BITS-1:0], rtl_wide[OUT_BITS-1:0]};
      if (plen_next != 2'd0 && plen_next != plen) begin
        unique case (plen)
          2'd0:    p0 <= in_byte;
          2'd1:    p1 <= in_byte;
          default: p2 <= in_byte;
        endcase
      end
    end
  end

endmodule
